/* rtl/core/bss_pkg.sv */
`default_nettype none

package bss_pkg;

   localparam int POS_W      = 18;
   localparam int DELTA_W    = POS_W + 1;
   localparam int CSR_W      = 16;
   localparam int SEED_W     = 32;
   localparam int MAX_STAMPS = 64;
   localparam int CNT_W      = $clog2(MAX_STAMPS + 1);

   // squared length, radicand and root
   localparam int SQ_W        = 2 * DELTA_W;
   localparam int RAD_W       = 54;
   localparam int ROOT_W      = 27;
   localparam int SQRT_ITERS  = ROOT_W;

   // shared shift-subtract divider
   localparam int STEP_W      = 2 * CSR_W;
   localparam int DIV_NUM_W   = ROOT_W + 8;
   localparam int DIV_REM_W   = STEP_W + 1;
   localparam int ITER_W      = 6;
   localparam int AXIS_PAD_W  = DIV_NUM_W - DELTA_W;

   localparam logic [CSR_W-1:0]  SPACING_FLOOR = 16'd1311;
   localparam logic [STEP_W-1:0] STEP_FLOOR    = 32'd8589935;
   localparam logic [SEED_W-1:0] SEED_BEGIN    = 32'd247071;
   localparam logic [SEED_W-1:0] SEED_STEP     = 32'd85852;

   localparam logic [CSR_W-1:0]  BRUSH_SIZE_RESET    = 16'd3277;
   localparam logic [CSR_W-1:0]  STAMP_SPACING_RESET = 16'd6554;

   // request codes
   localparam logic [1:0] REQ_BEGIN    = 2'd0;
   localparam logic [1:0] REQ_CONTINUE = 2'd1;
   localparam logic [1:0] REQ_END      = 2'd2;

   // register indexes
   localparam logic CSR_BRUSH_SIZE    = 1'b0;
   localparam logic CSR_STAMP_SPACING = 1'b1;

   typedef enum logic {
      OP_BEGIN,
      OP_SEGMENT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BEGIN,
      ST_PREP,
      ST_SQX,
      ST_SQY,
      ST_SQRT,
      ST_DIV,
      ST_DIVX,
      ST_DIVY,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/bss_cmd_queue.sv */
`default_nettype none

module bss_cmd_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  bss_pkg::cmd_type     push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 valid,
   output bss_pkg::cmd_type     head
);

   bss_pkg::cmd_type entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bss_front.sv */
`default_nettype none

module bss_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_push,
   output logic                         req_full,
   input  wire  [1:0]                   req_type,
   input  wire  [bss_pkg::POS_W-1:0]    req_pos_x,
   input  wire  [bss_pkg::POS_W-1:0]    req_pos_y,
   input  wire                          q_full,
   output logic                         q_push,
   output bss_pkg::cmd_type             q_data
);

   logic stroke_ff, stroke_in;
   logic accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // the stroke flag depends only on the event sequence, so it lives here
   always_comb begin
      stroke_in = stroke_ff;
      q_push    = 1'b0;
      q_data.x  = req_pos_x;
      q_data.y  = req_pos_y;
      q_data.op = bss_pkg::OP_BEGIN;
      if (accept) begin
         unique case (req_type)
            bss_pkg::REQ_BEGIN: begin
               q_push    = 1'b1;
               stroke_in = 1'b1;
            end
            bss_pkg::REQ_CONTINUE: begin
               q_push    = 1'b1;
               q_data.op = stroke_ff ? bss_pkg::OP_SEGMENT : bss_pkg::OP_BEGIN;
               stroke_in = 1'b1;
            end
            bss_pkg::REQ_END: begin
               stroke_in = 1'b0;
            end
            default: begin
               stroke_in = stroke_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_ff <= 1'b0;
      end else begin
         stroke_ff <= stroke_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bss_back.sv */
`default_nettype none

module bss_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire  [bss_pkg::CSR_W-1:0]    csr_wdata,
   input  wire                          cmd_valid,
   input  bss_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   input  wire                          rsp_pop,
   output logic                         rsp_empty,
   output logic [bss_pkg::POS_W-1:0]    rsp_stamp_x,
   output logic [bss_pkg::POS_W-1:0]    rsp_stamp_y,
   output logic [bss_pkg::SEED_W-1:0]   rsp_stamp_seed,
   output logic                         rsp_last_stamp
);

   localparam int PW = bss_pkg::POS_W;
   localparam int DW = bss_pkg::DELTA_W;
   localparam int CW = bss_pkg::CNT_W;
   localparam int SW = bss_pkg::SEED_W;
   localparam int NW = bss_pkg::DIV_NUM_W;
   localparam int RW = bss_pkg::DIV_REM_W;
   localparam int TW = bss_pkg::STEP_W;
   localparam int AW = bss_pkg::RAD_W;
   localparam int IW = bss_pkg::ITER_W;

   bss_pkg::state_type state_ff, state_in;

   logic [bss_pkg::CSR_W-1:0] size_ff, spacing_ff;

   logic [PW-1:0]   last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [SW-1:0]   seed_ff, seed_in;
   logic [PW-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [TW-1:0]   step_ff, step_in;
   logic [bss_pkg::SQ_W-1:0] sq_ff, sq_in;
   logic [AW-1:0]   rad_ff, rad_in, bit_ff, bit_in;
   logic [AW:0]     root_ff, root_in;
   logic [IW-1:0]   iter_ff, iter_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]   num_ff, num_in, quo_ff, quo_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [DW-1:0]   ax_ff, ax_in, ay_ff, ay_in, qx_ff, qx_in, qy_ff, qy_in;
   logic [CW-1:0]   bx_ff, bx_in, by_ff, by_in, rx_ff, rx_in, ry_ff, ry_in;
   logic [CW-1:0]   idx_ff, idx_in;

   logic            out_valid_ff, out_valid_in, out_load;
   logic [PW-1:0]   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [SW-1:0]   out_seed_ff, out_seed_in;
   logic            out_last_ff, out_last_in;
   logic            slot_free;

   // combinational helpers
   logic [bss_pkg::CSR_W-1:0] sp_eff;
   logic [TW-1:0]   step_raw;
   logic signed [2*DW-1:0] sq_prod;
   logic [AW:0]     trial;
   logic [TW-1:0]   den;
   logic [RW-1:0]   rem_sh;
   logic            div_ge;
   logic [DW-1:0]   mag_x, mag_y;
   logic [CW:0]     rx_sum, ry_sum;
   logic            wrap_x, wrap_y;
   logic [DW-1:0]   qx_new, qy_new;
   logic [DW:0]     px, py, sx, sy;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_stamp_x    = out_x_ff;
   assign rsp_stamp_y    = out_y_ff;
   assign rsp_stamp_seed = out_seed_ff;
   assign rsp_last_stamp = out_last_ff;
   assign slot_free      = !out_valid_ff || rsp_pop;

   always_comb begin
      sp_eff   = (spacing_ff < bss_pkg::SPACING_FLOOR) ? bss_pkg::SPACING_FLOOR : spacing_ff;
      step_raw = TW'(size_ff) * TW'(sp_eff);
      sq_prod  = (state_ff == bss_pkg::ST_SQX) ? dx_ff * dx_ff : dy_ff * dy_ff;
      trial    = root_ff + {1'b0, bit_ff};
      den      = (state_ff == bss_pkg::ST_DIV) ? step_ff : TW'(count_ff);
      rem_sh   = {rem_ff[RW-2:0], num_ff[NW-1]};
      div_ge   = (rem_sh >= {1'b0, den});
      mag_x    = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
      mag_y    = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
      rx_sum   = {1'b0, rx_ff} + {1'b0, bx_ff};
      ry_sum   = {1'b0, ry_ff} + {1'b0, by_ff};
      wrap_x   = (rx_sum >= {1'b0, count_ff});
      wrap_y   = (ry_sum >= {1'b0, count_ff});
      qx_new   = qx_ff + ax_ff + DW'(wrap_x);
      qy_new   = qy_ff + ay_ff + DW'(wrap_y);
      px       = dx_ff[DW-1] ? -{1'b0, qx_new} : {1'b0, qx_new};
      py       = dy_ff[DW-1] ? -{1'b0, qy_new} : {1'b0, qy_new};
      sx       = {{2{last_x_ff[PW-1]}}, last_x_ff} + px;
      sy       = {{2{last_y_ff[PW-1]}}, last_y_ff} + py;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_pop     = 1'b0;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      seed_in     = seed_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      step_in     = step_ff;
      sq_in       = sq_ff;
      rad_in      = rad_ff;
      bit_in      = bit_ff;
      root_in     = root_ff;
      iter_in     = iter_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      count_in    = count_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      bx_in       = bx_ff;
      by_in       = by_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      idx_in      = idx_ff;
      out_load    = 1'b0;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_seed_in = out_seed_ff;
      out_last_in = out_last_ff;

      unique case (state_ff)
         bss_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cur_x_in = cmd.x;
               cur_y_in = cmd.y;
               state_in = (cmd.op == bss_pkg::OP_BEGIN) ? bss_pkg::ST_BEGIN
                                                        : bss_pkg::ST_PREP;
            end
         end
         bss_pkg::ST_BEGIN: begin
            if (slot_free) begin
               seed_in     = seed_ff + bss_pkg::SEED_BEGIN;
               out_load    = 1'b1;
               out_x_in    = cur_x_ff;
               out_y_in    = cur_y_ff;
               out_seed_in = seed_ff + bss_pkg::SEED_BEGIN;
               out_last_in = 1'b1;
               last_x_in   = cur_x_ff;
               last_y_in   = cur_y_ff;
               state_in    = bss_pkg::ST_IDLE;
            end
         end
         bss_pkg::ST_PREP: begin
            dx_in    = DW'(signed'(cur_x_ff)) - DW'(signed'(last_x_ff));
            dy_in    = DW'(signed'(cur_y_ff)) - DW'(signed'(last_y_ff));
            step_in  = (step_raw < bss_pkg::STEP_FLOOR) ? bss_pkg::STEP_FLOOR : step_raw;
            state_in = bss_pkg::ST_SQX;
         end
         bss_pkg::ST_SQX: begin
            sq_in    = bss_pkg::SQ_W'(sq_prod);
            state_in = bss_pkg::ST_SQY;
         end
         bss_pkg::ST_SQY: begin
            rad_in   = AW'({sq_ff + bss_pkg::SQ_W'(sq_prod), 16'd0});
            root_in  = '0;
            bit_in   = AW'(1) << (AW - 2);
            iter_in  = IW'(bss_pkg::SQRT_ITERS - 1);
            state_in = bss_pkg::ST_SQRT;
         end
         bss_pkg::ST_SQRT: begin
            if ({1'b0, rad_ff} >= trial) begin
               rad_in  = AW'({1'b0, rad_ff} - trial);
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff - IW'(1);
            if (iter_ff == '0) begin
               rem_in   = '0;
               quo_in   = '0;
               num_in   = {root_in[bss_pkg::ROOT_W-1:0], 8'd0};
               iter_in  = IW'(NW - 1);
               state_in = bss_pkg::ST_DIV;
            end
         end
         bss_pkg::ST_DIV, bss_pkg::ST_DIVX, bss_pkg::ST_DIVY: begin
            rem_in  = div_ge ? (rem_sh - {1'b0, den}) : rem_sh;
            num_in  = num_ff << 1;
            quo_in  = {quo_ff[NW-2:0], div_ge};
            iter_in = iter_ff - IW'(1);
            if (iter_ff == '0) begin
               rem_in  = '0;
               iter_in = IW'(DW - 1);
               if (state_ff == bss_pkg::ST_DIV) begin
                  if (quo_in == '0) begin
                     state_in = bss_pkg::ST_IDLE;
                  end else begin
                     count_in = (quo_in > NW'(bss_pkg::MAX_STAMPS))
                                ? CW'(bss_pkg::MAX_STAMPS) : CW'(quo_in);
                     num_in   = {mag_x, {bss_pkg::AXIS_PAD_W{1'b0}}};
                     quo_in   = '0;
                     state_in = bss_pkg::ST_DIVX;
                  end
               end else if (state_ff == bss_pkg::ST_DIVX) begin
                  ax_in    = quo_in[DW-1:0];
                  bx_in    = rem_in == '0 ? CW'(div_ge ? rem_sh - {1'b0, den} : rem_sh)
                                          : CW'(rem_sh);
                  num_in   = {mag_y, {bss_pkg::AXIS_PAD_W{1'b0}}};
                  quo_in   = '0;
                  state_in = bss_pkg::ST_DIVY;
               end else begin
                  ay_in    = quo_in[DW-1:0];
                  by_in    = CW'(div_ge ? rem_sh - {1'b0, den} : rem_sh);
                  qx_in    = '0;
                  qy_in    = '0;
                  rx_in    = count_ff >> 1;
                  ry_in    = count_ff >> 1;
                  idx_in   = CW'(1);
                  state_in = bss_pkg::ST_EMIT;
               end
            end
         end
         bss_pkg::ST_EMIT: begin
            if (slot_free) begin
               qx_in       = qx_new;
               qy_in       = qy_new;
               rx_in       = wrap_x ? CW'(rx_sum - {1'b0, count_ff}) : CW'(rx_sum);
               ry_in       = wrap_y ? CW'(ry_sum - {1'b0, count_ff}) : CW'(ry_sum);
               seed_in     = seed_ff + bss_pkg::SEED_STEP;
               out_load    = 1'b1;
               out_x_in    = sx[PW-1:0];
               out_y_in    = sy[PW-1:0];
               out_seed_in = seed_ff + bss_pkg::SEED_STEP;
               out_last_in = (idx_ff == count_ff);
               idx_in      = idx_ff + CW'(1);
               if (idx_ff == count_ff) begin
                  last_x_in = cur_x_ff;
                  last_y_in = cur_y_ff;
                  state_in  = bss_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bss_pkg::ST_IDLE;
         end
      endcase

      out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bss_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         seed_ff      <= '0;
         size_ff      <= bss_pkg::BRUSH_SIZE_RESET;
         spacing_ff   <= bss_pkg::STAMP_SPACING_RESET;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         seed_ff      <= seed_in;
         if (csr_we && csr_index == bss_pkg::CSR_BRUSH_SIZE) begin
            size_ff <= csr_wdata;
         end
         if (csr_we && csr_index == bss_pkg::CSR_STAMP_SPACING) begin
            spacing_ff <= csr_wdata;
         end
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      step_ff     <= step_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      bit_ff      <= bit_in;
      root_ff     <= root_in;
      iter_ff     <= iter_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      count_ff    <= count_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      idx_ff      <= idx_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_seed_ff <= out_seed_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

/* rtl/core/brush_stroke_stamp_spacer.sv */
// channel    | direction | handshake          | payload
// req        | in        | req_push/req_full  | req_type, req_pos_x, req_pos_y
// rsp        | out       | rsp_pop/rsp_empty  | rsp_stamp_x/_y, rsp_stamp_seed, rsp_last_stamp
// csr        | in        | csr_we             | csr_index, csr_wdata
//
// begin stamp: the event queue, then the idle and begin states, lie between the req
//   transaction and rsp_empty low; the begin state waits for a free output slot
// segment: the 27-step square root, the shared divider (35 steps for the stamp count,
//   19 steps per axis) and the emit state lie between the req transaction and the last stamp
// stamps of one segment leave at one per cycle while rsp_pop keeps up
// a two-entry event queue lets req transactions in while the back end works
// synchronous active-high reset, no clearing pass
`default_nettype none

module brush_stroke_stamp_spacer (
   input  wire                          clock,
   input  wire                          reset,
   // pointer events
   input  wire                          req_push,
   output logic                         req_full,
   input  wire  [1:0]                   req_type,
   input  wire  [bss_pkg::POS_W-1:0]    req_pos_x,
   input  wire  [bss_pkg::POS_W-1:0]    req_pos_y,
   // stamps
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output logic [bss_pkg::POS_W-1:0]    rsp_stamp_x,
   output logic [bss_pkg::POS_W-1:0]    rsp_stamp_y,
   output logic [bss_pkg::SEED_W-1:0]   rsp_stamp_seed,
   output logic                         rsp_last_stamp,
   // brush registers
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire  [bss_pkg::CSR_W-1:0]    csr_wdata
);

   logic             q_full, q_push, q_valid, q_pop;
   bss_pkg::cmd_type q_data, q_head;

   // front end: stroke tracking, drops end and unknown events
   bss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_type  (req_type),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   // decoupling queue between classification and stamp generation
   bss_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // back end: begin stamps, segment length, stamp count and interpolation
   bss_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd_valid      (q_valid),
      .cmd            (q_head),
      .cmd_pop        (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_stamp_x    (rsp_stamp_x),
      .rsp_stamp_y    (rsp_stamp_y),
      .rsp_stamp_seed (rsp_stamp_seed),
      .rsp_last_stamp (rsp_last_stamp)
   );

endmodule

`default_nettype wire

/* rtl/core/bss_checker.sv */
`default_nettype none

module bss_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_full,
   input wire                          rsp_empty,
   input wire                          rsp_pop,
   input wire [bss_pkg::POS_W-1:0]     rsp_stamp_x,
   input wire [bss_pkg::SEED_W-1:0]    rsp_stamp_seed,
   input wire                          rsp_last_stamp
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("event queue full after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_stamp_x)
                                 && $stable(rsp_stamp_seed))
      else $error("waiting stamp changed");

   a_seed_step: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !rsp_last_stamp |=>
         rsp_empty || rsp_stamp_seed == $past(rsp_stamp_seed) + bss_pkg::SEED_STEP)
      else $error("seed step wrong within a segment");

endmodule

bind brush_stroke_stamp_spacer bss_checker u_bss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_stamp_x    (rsp_stamp_x),
   .rsp_stamp_seed (rsp_stamp_seed),
   .rsp_last_stamp (rsp_last_stamp)
);

`default_nettype wire
